### rtl/gcd_pkg.sv
// Shared types, constants and elaboration-time table functions for the
// great circle distance pipeline. Depends on nothing; every other file imports it.

package gcd_pkg;

    // Number formats: signed Q2.F internally, F = ANGLE_BITS - 2.
    localparam int ANGLE_BITS       = 32;
    localparam int FRAC_BITS        = ANGLE_BITS - 2;
    localparam int DEF_CORDIC_STEPS = 32;
    localparam int ROOT_STEPS       = FRAC_BITS + 1;
    localparam int W                = ANGLE_BITS + 4;

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [31:0] RAD_CAP = 32'd3373259426;
    localparam logic [31:0] DEG_CAP = 32'd3019898880;

    // One rotation-mode cell's working set.
    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic                flip;
    } t_rot;

    // One vectoring-mode cell's working set.
    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
    } t_vec;

    // One square root cell: radicand, partial remainder and partial root.
    typedef struct packed {
        logic [ROOT_STEPS-1:0] v;
        logic [ROOT_STEPS+1:0] rem;
        logic [ROOT_STEPS-1:0] root;
    } t_root;

    // 64x64 product shifted right, truncated to 64 bits.
    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    // Power of two in Q62, or zero once it falls below the last bit.
    function automatic logic [63:0] arc_term(input int e);
        logic [63:0] t;
        t = 64'd0;
        if (e <= 62) begin
            t = 64'd1 << (62 - e);
        end
        return t;
    endfunction

    // atan(2^-i) by its series in Q62, rounded to Q2.F.
    function automatic logic [63:0] arc_q(input int i);
        logic [63:0] v;
        if (i == 0) begin
            v = PI_Q60;
        end else begin
            v = arc_term(i) - arc_term(3*i)/3 + arc_term(5*i)/5 - arc_term(7*i)/7
              + arc_term(9*i)/9 - arc_term(11*i)/11 + arc_term(13*i)/13
              - arc_term(15*i)/15 + arc_term(17*i)/17 - arc_term(19*i)/19
              + arc_term(21*i)/21 - arc_term(23*i)/23 + arc_term(25*i)/25
              - arc_term(27*i)/27 + arc_term(29*i)/29 - arc_term(31*i)/31
              + arc_term(33*i)/33 - arc_term(35*i)/35 + arc_term(37*i)/37
              - arc_term(39*i)/39 + arc_term(41*i)/41 - arc_term(43*i)/43
              + arc_term(45*i)/45 - arc_term(47*i)/47 + arc_term(49*i)/49
              - arc_term(51*i)/51 + arc_term(53*i)/53 - arc_term(55*i)/55
              + arc_term(57*i)/57 - arc_term(59*i)/59 + arc_term(61*i)/61;
        end
        return (v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    endfunction

    // Inverse CORDIC gain: Newton iteration for 1/sqrt(prod(1+4^-i)).
    function automatic logic [63:0] gain_q(input int steps);
        logic [63:0] p;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] u;
        p = 64'h8000_0000_0000_0000;
        y = 64'd1 << 61;
        for (int i = 1; i < steps; i++) begin
            if (2*i < 64) begin
                p = p + (p >> (2*i));
            end
        end
        for (int k = 0; k < 12; k++) begin
            t = mul_shr(y, y, 62);
            u = mul_shr(p, t, 62);
            y = mul_shr(y, 64'hC000_0000_0000_0000 - u, 63);
        end
        return (y + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    endfunction

    // 180/pi in Q50 by long division.
    function automatic logic [63:0] r2d_q50();
        logic [63:0] rem;
        logic [63:0] q;
        rem = 64'd180;
        q   = 64'd0;
        for (int k = 0; k < 110; k++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= PI_Q60) begin
                rem = rem - PI_Q60;
                q   = q | 64'd1;
            end
        end
        return q;
    endfunction

endpackage

### rtl/gcd_rot_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation, registered.
// Depends on gcd_pkg.

module gcd_rot_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  gcd_pkg::t_rot i_d,
    output gcd_pkg::t_rot o_d
);
    import gcd_pkg::*;

    localparam logic signed [W-1:0] ARC = W'(arc_q(STEP));

    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    t_rot                n_d;
    t_rot                r_d;

    // Rotate toward zero residual angle.
    always_comb begin
        dx     = $signed(i_d.y) >>> STEP;
        dy     = $signed(i_d.x) >>> STEP;
        n_d    = i_d;
        if (!i_d.z[W-1]) begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - ARC;
        end else begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + ARC;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

### rtl/gcd_root_cell.sv
// One digit of a restoring square root: one result bit per cell, registered.
// Depends on gcd_pkg.

module gcd_root_cell #(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  gcd_pkg::t_root i_d,
    output gcd_pkg::t_root o_d
);
    import gcd_pkg::*;

    logic [2*ROOT_STEPS-1:0] rad;
    logic [ROOT_STEPS+3:0]   rem_x;
    logic [ROOT_STEPS+3:0]   trial;
    t_root                   n_d;
    t_root                   r_d;

    // The radicand is v scaled up by the fraction width.
    always_comb begin
        rad     = {1'b0, i_d.v, {FRAC_BITS{1'b0}}};
        rem_x   = {i_d.rem, rad[2*K+1 -: 2]};
        trial   = {2'b00, i_d.root, 2'b01};
        n_d.v   = i_d.v;
        if (rem_x >= trial) begin
            n_d.rem  = (ROOT_STEPS+2)'(rem_x - trial);
            n_d.root = {i_d.root[ROOT_STEPS-2:0], 1'b1};
        end else begin
            n_d.rem  = rem_x[ROOT_STEPS+1:0];
            n_d.root = {i_d.root[ROOT_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

### rtl/gcd_vec_cell.sv
// One vectoring-mode CORDIC cell: drives y toward zero, accumulates the angle.
// Depends on gcd_pkg.

module gcd_vec_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  gcd_pkg::t_vec i_d,
    output gcd_pkg::t_vec o_d
);
    import gcd_pkg::*;

    localparam logic signed [W-1:0] ARC = W'(arc_q(STEP));

    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    t_vec                n_d;
    t_vec                r_d;

    // Rotate the vector onto the x axis.
    always_comb begin
        dx = $signed(i_d.y) >>> STEP;
        dy = $signed(i_d.x) >>> STEP;
        if (!i_d.y[W-1]) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + ARC;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - ARC;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

### rtl/great_circle_distance.sv
// Top level of the haversine great circle distance pipeline.
// Depends on gcd_pkg, gcd_rot_cell, gcd_root_cell and gcd_vec_cell.
//
//   channel   direction  handshake            payload
//   request   in         start / busy         i_first_latitude .. i_second_longitude
//   result    out        o_valid strobe       o_central_angle
//   config    in         i_cfg_we             i_cfg_wdata (output_in_degrees)
//
// One request enters per cycle; busy never rises. Each result's delay from its
// request is set by the two CORDIC cell rows (one cell per step), the square
// root row (one cell per root bit) and the registered stages around them.
// Reset clears only the valid pipe and the unit bit. Results are strobed for
// one cycle and cannot be held off, so nothing in the pipe ever stalls.

module great_circle_distance #(
    parameter int CORDIC_STEPS = gcd_pkg::DEF_CORDIC_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_first_latitude,
    input  logic [31:0] i_first_longitude,
    input  logic [31:0] i_second_latitude,
    input  logic [31:0] i_second_longitude,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_valid,
    output logic [31:0] o_central_angle
);
    import gcd_pkg::*;

    localparam int LAT = 2*CORDIC_STEPS + ROOT_STEPS + 8;

    localparam logic signed [33:0] HALF = 34'sd2147483648;
    localparam logic signed [33:0] TURN = 34'sd4294967296;
    localparam logic [30:0]        PI_HI = PI_Q60[61:31];
    localparam logic [30:0]        PI_LO = PI_Q60[30:0];
    localparam logic [63:0]        GAIN64 = gain_q(CORDIC_STEPS);
    localparam logic signed [W-1:0] GAIN = GAIN64[W-1:0];
    localparam logic [63:0]        R2D = r2d_q50();
    localparam logic [27:0]        R2D_HI = R2D[55:28];
    localparam logic [27:0]        R2D_LO = R2D[27:0];
    localparam logic [ROOT_STEPS-1:0] ONE = ROOT_STEPS'(1) << FRAC_BITS;

    // Valid pipe and the unit bit.
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;
    logic           r_deg;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[LAT-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_deg <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_deg <= i_cfg_wdata;
            end
        end
    end

    assign o_valid = r_vld[LAT-1];

    // Stage A: the four half angles, folded into the right half plane.
    logic signed [31:0] dlon;
    logic signed [33:0] a_t [4];
    logic signed [33:0] a_f [4];
    logic               a_flip [4];
    logic [31:0]        n_a_mag [4];
    logic [31:0]        r_a_mag [4];
    logic               r_a_neg [4];
    logic               r_a_flip [4];

    assign dlon   = $signed(i_first_longitude) - $signed(i_second_longitude);
    assign a_t[0] = 34'($signed(i_first_latitude)) - 34'($signed(i_second_latitude));
    assign a_t[1] = 34'(dlon);
    assign a_t[2] = {i_first_latitude[31], i_first_latitude, 1'b0};
    assign a_t[3] = {i_second_latitude[31], i_second_latitude, 1'b0};

    // Stage M1/M2 and the rotation rows, one per angle.
    logic [62:0]  r_m_hi [4];
    logic [62:0]  r_m_lo [4];
    logic         r_m_neg [4];
    logic         r_m_flip [4];
    logic [94:0]  m_sum [4];
    logic [32:0]  m_zmag [4];
    t_rot         r_rot0 [4];
    t_rot         rot_c [4][CORDIC_STEPS+1];

    for (genvar c = 0; c < 4; c++) begin : g_chan
        always_comb begin
            a_f[c]    = a_t[c];
            a_flip[c] = 1'b0;
            if (a_t[c] > HALF) begin
                a_f[c]    = a_t[c] - TURN;
                a_flip[c] = 1'b1;
            end else if (a_t[c] < -HALF) begin
                a_f[c]    = a_t[c] + TURN;
                a_flip[c] = 1'b1;
            end
            n_a_mag[c] = a_f[c][33] ? 32'(-a_f[c]) : 32'(a_f[c]);
        end

        always_ff @(posedge i_clk) begin
            r_a_mag[c]  <= n_a_mag[c];
            r_a_neg[c]  <= a_f[c][33];
            r_a_flip[c] <= a_flip[c];
        end

        // Angle times pi, split into two partial products.
        always_ff @(posedge i_clk) begin
            r_m_hi[c]   <= 63'(r_a_mag[c]) * 63'(PI_HI);
            r_m_lo[c]   <= 63'(r_a_mag[c]) * 63'(PI_LO);
            r_m_neg[c]  <= r_a_neg[c];
            r_m_flip[c] <= r_a_flip[c];
        end

        assign m_sum[c]  = {r_m_hi[c], 32'd0} + 95'(r_m_lo[c]) - 95'(0)
                         + 95'(0) - ({r_m_hi[c], 32'd0} - {1'b0, r_m_hi[c], 31'd0});
        assign m_zmag[c] = m_sum[c][94:62];

        always_ff @(posedge i_clk) begin
            r_rot0[c].x    <= GAIN;
            r_rot0[c].y    <= '0;
            r_rot0[c].z    <= r_m_neg[c] ? -W'(m_zmag[c]) : W'(m_zmag[c]);
            r_rot0[c].flip <= r_m_flip[c];
        end

        assign rot_c[c][0] = r_rot0[c];

        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
            gcd_rot_cell #(.STEP(i)) u_cell (
                .i_clk (i_clk),
                .i_d   (rot_c[c][i]),
                .o_d   (rot_c[c][i+1])
            );
        end
    end

    // Sines and cosines with the half turn restored.
    logic signed [W-1:0] s_a;
    logic signed [W-1:0] s_b;
    logic signed [W-1:0] c_1;
    logic signed [W-1:0] c_2;
    t_rot                e_a;
    t_rot                e_b;
    t_rot                e_1;
    t_rot                e_2;

    assign e_a = rot_c[0][CORDIC_STEPS];
    assign e_b = rot_c[1][CORDIC_STEPS];
    assign e_1 = rot_c[2][CORDIC_STEPS];
    assign e_2 = rot_c[3][CORDIC_STEPS];
    assign s_a = e_a.flip ? -e_a.y : e_a.y;
    assign s_b = e_b.flip ? -e_b.y : e_b.y;
    assign c_1 = e_1.flip ? -e_1.x : e_1.x;
    assign c_2 = e_2.flip ? -e_2.x : e_2.x;

    // Stage P1: squares and the cosine product, on magnitudes.
    logic [31:0] p_ma;
    logic [31:0] p_mb;
    logic [31:0] p_m1;
    logic [31:0] p_m2;
    logic [63:0] p_sa2;
    logic [63:0] p_sb2;
    logic [63:0] p_c12;
    logic [33:0] r_sa2;
    logic [33:0] r_sb2;
    logic [33:0] r_c12;
    logic        r_c12_neg;

    assign p_ma  = s_a[W-1] ? 32'(-s_a) : 32'(s_a);
    assign p_mb  = s_b[W-1] ? 32'(-s_b) : 32'(s_b);
    assign p_m1  = c_1[W-1] ? 32'(-c_1) : 32'(c_1);
    assign p_m2  = c_2[W-1] ? 32'(-c_2) : 32'(c_2);
    assign p_sa2 = p_ma * p_ma;
    assign p_sb2 = p_mb * p_mb;
    assign p_c12 = p_m1 * p_m2;

    always_ff @(posedge i_clk) begin
        r_sa2     <= p_sa2[63:30];
        r_sb2     <= p_sb2[63:30];
        r_c12     <= p_c12[63:30];
        r_c12_neg <= c_1[W-1] ^ c_2[W-1];
    end

    // Stage P2: the longitude term.
    logic [63:0] p_lon;
    logic [33:0] r_lon;
    logic        r_lon_neg;
    logic [33:0] r_sa2_d;

    assign p_lon = r_c12[31:0] * r_sb2[31:0];

    always_ff @(posedge i_clk) begin
        r_lon     <= p_lon[63:30];
        r_lon_neg <= r_c12_neg;
        r_sa2_d   <= r_sa2;
    end

    // Stage P3: the haversine sum, held to the unit interval.
    logic signed [W-1:0]   h_sum;
    logic [ROOT_STEPS-1:0] n_h;
    logic [ROOT_STEPS-1:0] r_h;

    always_comb begin
        h_sum = r_lon_neg ? W'(r_sa2_d) - W'(r_lon) : W'(r_sa2_d) + W'(r_lon);
        if (h_sum[W-1]) begin
            n_h = '0;
        end else if (h_sum > W'(ONE)) begin
            n_h = ONE;
        end else begin
            n_h = ROOT_STEPS'(h_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
    end

    // Square root rows: sqrt(h) and sqrt(1-h).
    t_root root_c [2][ROOT_STEPS+1];

    assign root_c[0][0] = '{v: r_h,       rem: '0, root: '0};
    assign root_c[1][0] = '{v: ONE - r_h, rem: '0, root: '0};

    for (genvar r = 0; r < 2; r++) begin : g_root
        for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_dig
            gcd_root_cell #(.K(ROOT_STEPS-1-g)) u_cell (
                .i_clk (i_clk),
                .i_d   (root_c[r][g]),
                .o_d   (root_c[r][g+1])
            );
        end
    end

    // Arctangent row.
    t_vec vec_c [CORDIC_STEPS+1];

    assign vec_c[0].x = W'(root_c[1][ROOT_STEPS].root);
    assign vec_c[0].y = W'(root_c[0][ROOT_STEPS].root);
    assign vec_c[0].z = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        gcd_vec_cell #(.STEP(i)) u_cell (
            .i_clk (i_clk),
            .i_d   (vec_c[i]),
            .o_d   (vec_c[i+1])
        );
    end

    // Stage O1: double the angle, split the degree product.
    logic signed [W-1:0] o_d2;
    logic [33:0]         o_du;
    logic [33:0]         r_du;
    logic [61:0]         r_dh;
    logic [61:0]         r_dl;

    assign o_d2 = vec_c[CORDIC_STEPS].z <<< 1;
    assign o_du = o_d2[W-1] ? 34'd0 : o_d2[33:0];

    always_ff @(posedge i_clk) begin
        r_du <= o_du;
        r_dh <= 62'(o_du) * 62'(R2D_HI);
        r_dl <= 62'(o_du) * 62'(R2D_LO);
    end

    // Stage O2: unit select and caps.
    logic [89:0] q_deg;
    logic [33:0] q_degv;
    logic [31:0] n_out;
    logic [31:0] r_out;

    always_comb begin
        q_deg  = {r_dh, 28'd0} + 90'(r_dl);
        q_degv = q_deg[89:56];
        if (r_deg) begin
            n_out = (q_degv > 34'(DEG_CAP)) ? DEG_CAP : q_degv[31:0];
        end else begin
            n_out = (r_du > 34'(RAD_CAP)) ? RAD_CAP : r_du[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_central_angle = r_out;

endmodule

### rtl/gcd_checker.sv
// Port-level checks for the great circle distance pipeline, bound to the top.
// Depends on gcd_pkg and great_circle_distance.

module gcd_checker #(
    parameter int CORDIC_STEPS = gcd_pkg::DEF_CORDIC_STEPS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_cfg_we,
    input logic        i_cfg_wdata,
    input logic        o_valid,
    input logic [31:0] o_central_angle
);
    import gcd_pkg::*;

    localparam int LAT = 2*CORDIC_STEPS + ROOT_STEPS + 8;
    localparam int CW  = $clog2(LAT + 1);

    logic [CW-1:0] r_cnt;
    logic          r_deg;

    // Cycles since reset, held once they reach LAT, and the unit bit as seen on the port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_deg <= 1'b0;
        end else begin
            if (r_cnt != CW'(LAT)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cfg_we) begin
                r_deg <= i_cfg_wdata;
            end
        end
    end

    // Every request yields exactly one result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CW'(LAT)) |-> (o_valid == $past(start && !busy, LAT)))
        else $error("result strobe does not match request latency");

    // Radian results stay within the cap.
    a_rad_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_deg) |-> (o_central_angle <= RAD_CAP))
        else $error("radian result above cap");

    // Degree results never exceed half a turn.
    a_deg_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_deg) |-> (o_central_angle <= DEG_CAP))
        else $error("degree result above cap");

endmodule

bind great_circle_distance gcd_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_gcd_checker (.*);
